// File: src/rse_pkg.sv
package rse_pkg;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // Run code marker, terminator byte and the longest run a code byte can hold.
  localparam logic [7:0]  RunMark  = 8'hE0;
  localparam logic [4:0]  RunLimit = 5'd31;

  // Encoded length saturates here.
  localparam logic [13:0] LenMax   = 14'h3FFF;

  // One run to be sent: pixel count and colour.
  typedef struct packed {
    logic       valid;
    logic [4:0] count;
    logic [7:0] colour;
  } run_t;

  // Work for the back, produced by one pixel.
  // The flush run goes first: a colour change or a run that hit the limit.
  // The tail run is the pending run flushed at the end of the line.
  // The terminator ends the line.
  typedef struct packed {
    run_t flush;
    run_t tail;
    logic term;
  } cmd_t;

endpackage

// File: src/rse_front.sv
module rse_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     pixel_i,
  input  logic           end_of_line_i,
  output logic           in_stall_o,
  input  logic           full_i,
  output logic           push_o,
  output rse_pkg::cmd_t  cmd_o
);

  logic [7:0] run_colour_q;
  logic [4:0] run_count_q;
  logic       line_open_q;

  logic       accept;
  logic [7:0] colour_d;
  logic [4:0] count_d;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Classify the pixel: which runs close and whether the line ends.
  always_comb begin
    cmd_o    = '0;
    colour_d = run_colour_q;
    count_d  = run_count_q;
    if (!line_open_q) begin
      colour_d = pixel_i;
      count_d  = 5'd1;
    end else begin
      if (pixel_i != run_colour_q) begin
        cmd_o.flush.valid  = (run_count_q != 5'd0);
        cmd_o.flush.count  = run_count_q;
        cmd_o.flush.colour = run_colour_q;
        colour_d           = pixel_i;
        count_d            = 5'd1;
      end else begin
        count_d = run_count_q + 5'd1;
      end
      if (count_d == rse_pkg::RunLimit) begin
        cmd_o.flush.valid  = 1'b1;
        cmd_o.flush.count  = rse_pkg::RunLimit;
        cmd_o.flush.colour = colour_d;
        count_d            = 5'd0;
      end
    end
    if (end_of_line_i) begin
      cmd_o.tail.valid  = (count_d != 5'd0);
      cmd_o.tail.count  = count_d;
      cmd_o.tail.colour = colour_d;
      cmd_o.term        = 1'b1;
    end
    push_o = accept && (cmd_o.flush.valid || cmd_o.tail.valid || cmd_o.term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_colour_q <= '0;
      run_count_q  <= '0;
      line_open_q  <= 1'b0;
    end else if (accept) begin
      if (end_of_line_i) begin
        run_colour_q <= '0;
        run_count_q  <= '0;
        line_open_q  <= 1'b0;
      end else begin
        run_colour_q <= colour_d;
        run_count_q  <= count_d;
        line_open_q  <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A run at the limit is flushed at once and never held.
  assert property (@(posedge clk_i) disable iff (!rst_ni) run_count_q != rse_pkg::RunLimit)
    else $error("run count held at limit");

  // A closed line holds no pending run.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !line_open_q |-> run_count_q == 5'd0)
    else $error("pending run outside a line");
`endif

endmodule

// File: src/rse_queue.sv
module rse_queue #(
  parameter int unsigned Depth = rse_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rse_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  output rse_pkg::cmd_t data_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rse_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (pop_i |-> valid_o) and (push_i |-> !full_o))
    else $error("queue pop when empty or push when full");
`endif

endmodule

// File: src/rse_back.sv
module rse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  rse_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    code_byte_o,
  output logic          final_byte_o,
  output logic [13:0]   encoded_length_o
);

  typedef enum logic [2:0] {
    PhFlushCode,
    PhFlushColour,
    PhTailCode,
    PhTailColour,
    PhTerm
  } phase_e;

  phase_e      phase_q;
  phase_e      first_phase;
  phase_e      cur_phase;
  phase_e      next_phase;
  logic        busy_q;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        final_q;
  logic [13:0] enc_len_q;
  logic [13:0] len_q;
  logic [13:0] len_inc;

  logic        flush_lit;
  logic        tail_lit;
  logic        load;
  logic        cmd_done;
  logic [7:0]  byte_d;
  logic        final_d;

  assign flush_lit = (cmd_i.flush.count == 5'd1) &&
                     ((cmd_i.flush.colour & rse_pkg::RunMark) != rse_pkg::RunMark);
  assign tail_lit  = (cmd_i.tail.count == 5'd1) &&
                     ((cmd_i.tail.colour & rse_pkg::RunMark) != rse_pkg::RunMark);

  assign load      = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = load && cmd_done;
  assign len_inc   = (len_q == rse_pkg::LenMax) ? len_q : len_q + 14'd1;

  always_comb begin
    if (cmd_i.flush.valid) begin
      first_phase = PhFlushCode;
    end else if (cmd_i.tail.valid) begin
      first_phase = PhTailCode;
    end else begin
      first_phase = PhTerm;
    end
    cur_phase = busy_q ? phase_q : first_phase;
  end

  // Pick the byte of the current phase and find the phase after it.
  always_comb begin
    byte_d     = rse_pkg::RunMark;
    final_d    = 1'b0;
    next_phase = PhTerm;
    cmd_done   = 1'b0;
    unique case (cur_phase)
      PhFlushCode, PhFlushColour: begin
        if (cur_phase == PhFlushCode && flush_lit) begin
          byte_d = cmd_i.flush.colour;
        end else if (cur_phase == PhFlushCode) begin
          byte_d = rse_pkg::RunMark | {3'b000, cmd_i.flush.count};
        end else begin
          byte_d = cmd_i.flush.colour;
        end
        if (cur_phase == PhFlushCode && !flush_lit) begin
          next_phase = PhFlushColour;
        end else if (cmd_i.tail.valid) begin
          next_phase = PhTailCode;
        end else if (cmd_i.term) begin
          next_phase = PhTerm;
        end else begin
          cmd_done = 1'b1;
        end
      end
      PhTailCode, PhTailColour: begin
        if (cur_phase == PhTailCode && tail_lit) begin
          byte_d = cmd_i.tail.colour;
        end else if (cur_phase == PhTailCode) begin
          byte_d = rse_pkg::RunMark | {3'b000, cmd_i.tail.count};
        end else begin
          byte_d = cmd_i.tail.colour;
        end
        if (cur_phase == PhTailCode && !tail_lit) begin
          next_phase = PhTailColour;
        end else if (cmd_i.term) begin
          next_phase = PhTerm;
        end else begin
          cmd_done = 1'b1;
        end
      end
      PhTerm: begin
        byte_d   = rse_pkg::RunMark;
        final_d  = 1'b1;
        cmd_done = 1'b1;
      end
      default: begin
        cmd_done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFlushCode;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      final_q     <= 1'b0;
      enc_len_q   <= '0;
      len_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      byte_q      <= byte_d;
      final_q     <= final_d;
      enc_len_q   <= final_d ? len_inc : 14'd0;
      len_q       <= final_d ? 14'd0 : len_inc;
      busy_q      <= !cmd_done;
      phase_q     <= next_phase;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_byte_o      = byte_q;
  assign final_byte_o     = final_q;
  assign encoded_length_o = enc_len_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && final_q |-> byte_q == rse_pkg::RunMark)
    else $error("final byte is not the terminator");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && !final_q |-> enc_len_q == 14'd0)
    else $error("length shown on a non-final byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cmd_valid_i)
    else $error("command left the queue mid-expansion");
`endif

endmodule

// File: src/rle_scanline_encoder.sv
// The first code byte of an accepted pixel is registered in the command queue and then in the output register.
// Throughput: one pixel per cycle while the command queue has room; the back sends
//   one byte per cycle when not stalled; a pixel that closes runs yields 1 to 5 bytes.
// The byte rate of the output register sets the sustained rate on changing colours;
//   runs of equal pixels pass at one per cycle.
// Reset (rst_ni, async, active low) closes the line, empties the queue and drops any byte.
module rle_scanline_encoder #(
  parameter int unsigned QUEUE_DEPTH = rse_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  code_byte_o,
  output logic        final_byte_o,
  output logic [13:0] encoded_length_o
);

  // Front: track the run, decide which runs close on each pixel.
  logic          push;
  logic          full;
  rse_pkg::cmd_t push_cmd;

  // Back: turn each command into code bytes, count the line length.
  logic          cmd_valid;
  logic          cmd_pop;
  rse_pkg::cmd_t head_cmd;

  rse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .pixel_i       (pixel_i),
    .end_of_line_i (end_of_line_i),
    .in_stall_o    (in_stall_o),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // Decouple the two sides: the front keeps taking pixels while bytes wait.
  rse_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .data_o  (head_cmd),
    .pop_i   (cmd_pop)
  );

  rse_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (head_cmd),
    .cmd_pop_o        (cmd_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_byte_o      (code_byte_o),
    .final_byte_o     (final_byte_o),
    .encoded_length_o (encoded_length_o)
  );

endmodule

// File: bench/rle_scanline_encoder_test.sv
module rle_scanline_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any beat on either channel before the run is declared hung.
  localparam int StallLimit = 20000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HoldCycles = 400;

  // Scoreboard: carries its own copy of the encoder state, turns every
  // accepted pixel into the code bytes it must produce, and checks the
  // output beats against them in order.
  class rle_scoreboard;
    typedef struct {
      logic [7:0]  code;
      logic        fin;
      logic [13:0] len;
    } code_beat_t;

    logic [7:0]  cur_colour;
    logic [4:0]  cur_count;
    logic        line_started;
    logic [13:0] line_bytes;
    code_beat_t  pending_bytes[$];
    int          errors;
    int          pixels_seen;
    int          lines_done;
    int          bytes_checked;

    function new();
      cur_colour   = '0;
      cur_count    = '0;
      line_started = 1'b0;
      line_bytes   = '0;
      errors       = 0;
      pixels_seen  = 0;
      lines_done   = 0;
      bytes_checked = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Append one byte to the expected stream; the length saturates.
    function void push_byte(logic [7:0] b, logic fin);
      code_beat_t e;
      if (line_bytes < rse_pkg::LenMax) line_bytes++;
      e.code = b;
      e.fin  = fin;
      e.len  = fin ? line_bytes : '0;
      pending_bytes.push_back(e);
    endfunction

    // Send the pending run: a literal for a lone low colour, else code + colour.
    function void flush_run();
      if (cur_count == 0) return;
      if (cur_count == 1 && (cur_colour & rse_pkg::RunMark) != rse_pkg::RunMark) begin
        push_byte(cur_colour, 1'b0);
      end else begin
        push_byte(rse_pkg::RunMark | {3'b000, cur_count}, 1'b0);
        push_byte(cur_colour, 1'b0);
      end
      cur_count = '0;
    endfunction

    function void note_pixel(logic [7:0] pix, logic eol);
      pixels_seen++;
      if (!line_started) begin
        cur_colour   = pix;
        cur_count    = 5'd1;
        line_started = 1'b1;
      end else begin
        if (pix != cur_colour) begin
          flush_run();
          cur_colour = pix;
          cur_count  = '0;
        end
        cur_count++;
        // A full run goes out at once and leaves nothing pending.
        if (cur_count == rse_pkg::RunLimit) begin
          push_byte(rse_pkg::RunMark | {3'b000, rse_pkg::RunLimit}, 1'b0);
          push_byte(cur_colour, 1'b0);
          cur_count = '0;
        end
      end
      if (eol) begin
        flush_run();
        push_byte(rse_pkg::RunMark, 1'b1);
        cur_colour   = '0;
        cur_count    = '0;
        line_started = 1'b0;
        line_bytes   = '0;
        lines_done++;
      end
    endfunction

    task check_byte(logic [7:0] code, logic fin, logic [13:0] len);
      code_beat_t e;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h fin=%0b len=%0d", code, fin, len));
        return;
      end
      e = pending_bytes.pop_front();
      if (code !== e.code)
        report_mismatch($sformatf("code_byte %02h, want %02h", code, e.code));
      if (fin !== e.fin)
        report_mismatch($sformatf("final_byte %0b, want %0b (code %02h)", fin, e.fin, e.code));
      if (len !== e.len)
        report_mismatch($sformatf("encoded_length %0d, want %0d", len, e.len));
    endtask

    task close_out();
      if (pending_bytes.size() != 0)
        report_mismatch($sformatf("%0d code bytes never arrived", pending_bytes.size()));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pixel_i       = '0;
  logic        end_of_line_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [7:0]  code_byte_o;
  logic        final_byte_o;
  logic [13:0] encoded_length_o;

  logic        hold_req      = 1'b0;
  int          hold_left     = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles  = 0;
  rle_scoreboard sb;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  rle_scanline_encoder u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .pixel_i,
    .end_of_line_i,
    .out_valid_o,
    .out_stall_i,
    .code_byte_o,
    .final_byte_o,
    .encoded_length_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predict on every accepted pixel beat; values are sampled before the edge updates.
  always @(posedge clk_i) begin
    if (rst_ni && in_fire) sb.note_pixel(pixel_i, end_of_line_i);
  end

  // Check every accepted code byte against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_fire) sb.check_byte(code_byte_o, final_byte_o, encoded_length_o);
  end

  // Receiver: random stall at the current rate, or a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: give up when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if (in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no beat for %0d cycles", StallLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pixel, maybe after a random idle gap, and hold it until taken.
  task automatic send_pixel(input logic [7:0] pix, input logic eol);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= pix;
    end_of_line_i <= eol;
    do @(posedge clk_i); while (!in_fire);
  endtask

  task automatic send_line(input logic [7:0] pixels[$]);
    foreach (pixels[i]) send_pixel(pixels[i], i == pixels.size() - 1);
  endtask

  // Colours biased toward a few repeats and toward the code-byte range.
  function automatic logic [7:0] pick_colour();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(3))
        0:       return 8'h00;
        1:       return 8'h41;
        2:       return 8'hDF;
        default: return 8'hE0;
      endcase
    end
    if (r < 60) return 8'hE0 + 8'($urandom_range(31));
    return 8'($urandom_range(255));
  endfunction

  // Run lengths: mostly short, some around the run limit, a few around twice it.
  function automatic int pick_run();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 1;
    if (r < 80) return $urandom_range(2, 6);
    if (r < 92) return $urandom_range(29, 33);
    if (r < 97) return $urandom_range(60, 64);
    return $urandom_range(7, 28);
  endfunction

  // Build and send one line of runs with random colours, or plain noise.
  task automatic random_line(input int len, input bit noisy);
    logic [7:0] pixels[$];
    logic [7:0] c;
    int run;
    while (pixels.size() < len) begin
      c   = noisy ? 8'($urandom_range(255)) : pick_colour();
      run = noisy ? 1 : pick_run();
      repeat (run) if (pixels.size() < len) pixels.push_back(c);
    end
    send_line(pixels);
  endtask

  task automatic random_lines(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      random_line(len, $urandom_range(99) < 30);
      sent += len;
    end
  endtask

  task automatic directed_lines();
    logic [7:0] pixels[$];
    // One-pixel lines at both ends of the range and around the code marker.
    pixels = '{8'h00}; send_line(pixels);
    pixels = '{8'hFF}; send_line(pixels);
    pixels = '{8'hE0}; send_line(pixels);
    pixels = '{8'hDF}; send_line(pixels);
    // Pair, a lone high colour, a literal, a pair of the top colour, two literals.
    pixels = '{8'h01, 8'h01, 8'hE0, 8'hDF, 8'hFF, 8'hFF, 8'h80, 8'h7F};
    send_line(pixels);
    pixels = '{8'hAA, 8'h55}; send_line(pixels);
    pixels = '{8'h33, 8'h33, 8'h33}; send_line(pixels);
  endtask

  // Full run exactly at the limit, a lone colour, a second full run and the line end.
  task automatic limit_run_line();
    logic [7:0] pixels[$];
    repeat (rse_pkg::RunLimit) pixels.push_back(8'h7F);
    pixels.push_back(8'h12);
    repeat (rse_pkg::RunLimit) pixels.push_back(8'hF0);
    send_line(pixels);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender mostly busy, receiver mostly stalled.
    send_idle_pct = 32;
    recv_idle_pct = 87;
    directed_lines();
    random_lines(50);

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 87;
    recv_idle_pct = 32;
    limit_run_line();
    random_lines(50);

    // Full rate; start with a long receiver hold-off so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    random_line(48, 1'b1);
    random_lines(50);
    in_valid_i <= 1'b0;

    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.close_out();

    $display("Encoded %0d pixels in %0d lines, checked %0d code bytes.",
             sb.pixels_seen, sb.lines_done, sb.bytes_checked);
    $display("Covered one-pixel lines, full runs, high lone colours and back-pressure.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
